>>> sv/voxel_cube_frame_buffer_core_defines.svh
`ifndef VOXEL_CUBE_FRAME_BUFFER_CORE_DEFINES_SVH
`define VOXEL_CUBE_FRAME_BUFFER_CORE_DEFINES_SVH

// Flag a condition that must never hold at a clock edge outside reset.
`define VCFB_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

// Check that a condition in one cycle is followed by another in the next cycle.
`define VCFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> sv/vcfb_pkg.sv
`default_nettype none

package vcfb_pkg;

   // Cube geometry
   localparam int MAX_EDGE            = 8;
   localparam int LAYER_COUNT         = 8;
   localparam int LAYER_BITS          = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Command codes
   typedef enum logic [3:0] {
      OP_READ          = 4'd0,
      OP_SET           = 4'd1,
      OP_CLEAR         = 4'd2,
      OP_FLIP          = 4'd3,
      OP_FILL_CUBE     = 4'd4,
      OP_LAYER_FULL    = 4'd5,
      OP_LAYER_EMPTY   = 4'd6,
      OP_LAYER_BORDER  = 4'd7,
      OP_LAYER_PATTERN = 4'd8,
      OP_SHIFT         = 4'd9
   } opcode_type;

   // Classified command as it travels from front to back
   typedef struct packed {
      opcode_type  opcode;
      logic        in_range;
      logic [2:0]  z_coord;
      logic [5:0]  bit_pos;
      logic [7:0]  pattern_byte;
      logic [2:0]  rot_count;
      logic [3:0]  clear_count;
   } cmd_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic nonempty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_MOD,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_ROTATE
   } back_state_type;

endpackage

`default_nettype wire

>>> sv/voxel_cube_frame_buffer_core.sv
// Voxel, fill and layer items each give one result when the back executes them; a shift
// item gives its result once the back has rotated by r (0..7), its rotation distance.
// The front takes no new item until it has pushed the last one; a shift first runs the
// front's eight-step remainder loop. The back rotates the used layers one position a cycle.
// Reset (synchronous): cube cleared to zero, edge size 8, queue and result register empty.
`default_nettype none

module voxel_cube_frame_buffer_core import vcfb_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [3:0]        csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [3:0]        req_opcode,
   input  wire logic [2:0]        req_x_coord,
   input  wire logic [2:0]        req_y_coord,
   input  wire logic [2:0]        req_z_coord,
   input  wire logic [7:0]        req_pattern_byte,
   input  wire logic signed [7:0] req_shift_steps,
   input  wire logic              req_wrap_mode,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_voxel_value,
   output logic                   rsp_coord_in_range
);

   logic [3:0]       edge_ff, edge_in;
   logic             q_push, q_pop;
   cmd_type          q_wdata, q_rdata;
   queue_status_type q_status;

   // Clamp the written edge size into 1..MAX_EDGE
   always_comb begin
      edge_in = edge_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == 4'd0) begin
            edge_in = 4'd1;
         end else if (csr_wr_data > 4'(MAX_EDGE)) begin
            edge_in = 4'(MAX_EDGE);
         end else begin
            edge_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= 4'(MAX_EDGE);
      end else begin
         edge_ff <= edge_in;
      end
   end

   vcfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .edge_size        (edge_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .req_pattern_byte (req_pattern_byte),
      .req_shift_steps  (req_shift_steps),
      .req_wrap_mode    (req_wrap_mode),
      .q_status         (q_status),
      .push             (q_push),
      .push_data        (q_wdata)
   );

   vcfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   vcfb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .edge_size          (edge_ff),
      .q_status           (q_status),
      .q_data             (q_rdata),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_voxel_value    (rsp_voxel_value),
      .rsp_coord_in_range (rsp_coord_in_range)
   );

endmodule

`default_nettype wire

>>> sv/vcfb_front.sv
`default_nettype none

`include "voxel_cube_frame_buffer_core_defines.svh"

module vcfb_front import vcfb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [3:0]       edge_size,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [3:0]       req_opcode,
   input  wire logic [2:0]       req_x_coord,
   input  wire logic [2:0]       req_y_coord,
   input  wire logic [2:0]       req_z_coord,
   input  wire logic [7:0]       req_pattern_byte,
   input  wire logic signed [7:0] req_shift_steps,
   input  wire logic             req_wrap_mode,
   input  wire queue_status_type q_status,
   output logic                  push,
   output cmd_type               push_data
);

   front_state_type state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   logic [7:0]      rem_ff, rem_in;
   logic [2:0]      step_ff, step_in;
   logic            neg_ff, neg_in;

   logic            accept;
   logic            z_in, all_in;
   logic [6:0]      pos_full;
   logic [7:0]      sraw, mag;
   logic [3:0]      clr_count;
   cmd_type         classified;
   logic [14:0]     div_shifted;
   logic            rem_ge;
   logic [3:0]      rot_diff;
   logic [2:0]      rot_count;

   // Classify the incoming item
   always_comb begin
      z_in     = {1'b0, req_z_coord} < edge_size;
      all_in   = z_in && ({1'b0, req_x_coord} < edge_size) && ({1'b0, req_y_coord} < edge_size);
      pos_full = ({4'b0, req_y_coord} * {3'b0, edge_size}) + {4'b0, req_x_coord};
      sraw     = req_shift_steps;
      mag      = sraw[7] ? (~sraw + 8'd1) : sraw;
      if (sraw[7] || req_wrap_mode) begin
         clr_count = 4'd0;
      end else if (mag < {4'b0, edge_size}) begin
         clr_count = mag[3:0];
      end else begin
         clr_count = edge_size;
      end
      classified.opcode       = opcode_type'(req_opcode);
      classified.z_coord      = req_z_coord;
      classified.bit_pos      = pos_full[5:0];
      classified.pattern_byte = req_pattern_byte;
      classified.rot_count    = 3'd0;
      classified.clear_count  = clr_count;
      unique case (opcode_type'(req_opcode))
         OP_READ, OP_SET, OP_CLEAR, OP_FLIP: classified.in_range = all_in;
         OP_FILL_CUBE, OP_SHIFT:             classified.in_range = 1'b1;
         OP_LAYER_FULL, OP_LAYER_EMPTY,
         OP_LAYER_BORDER, OP_LAYER_PATTERN:  classified.in_range = z_in;
         default:                            classified.in_range = 1'b0;
      endcase
   end

   // Restoring remainder step: shift_steps mod edge_size, one quotient bit a cycle
   always_comb begin
      div_shifted = {11'b0, edge_size} << step_ff;
      rem_ge      = {7'b0, rem_ff} >= div_shifted;
      rot_diff    = edge_size - rem_ff[3:0];
      if (!neg_ff) begin
         rot_count = rem_ff[2:0];
      end else if (rem_ff == 8'd0) begin
         rot_count = 3'd0;
      end else begin
         rot_count = rot_diff[2:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_valid) begin
               state_in = (opcode_type'(req_opcode) == OP_SHIFT) ? FRONT_MOD : FRONT_PUSH;
            end
         end
         FRONT_MOD: begin
            if (step_ff == 3'd0) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (!q_status.full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall           = (state_ff != FRONT_IDLE);
      accept              = (state_ff == FRONT_IDLE) && req_valid;
      push                = (state_ff == FRONT_PUSH);
      push_data           = cmd_ff;
      push_data.rot_count = rot_count;
   end

   // Hold the item and advance the remainder
   always_comb begin
      cmd_in  = cmd_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      if (accept) begin
         cmd_in  = classified;
         rem_in  = mag;
         step_in = 3'd7;
         neg_in  = sraw[7];
      end else if (state_ff == FRONT_MOD) begin
         if (rem_ge) begin
            rem_in = rem_ff - div_shifted[7:0];
         end
         step_in = step_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

   `VCFB_ASSERT_NEVER(front_rot_bound, clock, reset, push && push_data.opcode == OP_SHIFT && 4'(push_data.rot_count) >= edge_size)

endmodule

`default_nettype wire

>>> sv/vcfb_queue.sv
`default_nettype none

`include "voxel_cube_frame_buffer_core_defines.svh"

module vcfb_queue import vcfb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire cmd_type  push_data,
   input  wire logic     pop,
   output cmd_type       pop_data,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr_en, rd_en;

   // Status and read port
   always_comb begin
      status.full     = (count_ff == CNT_W'(DEPTH));
      status.nonempty = (count_ff != '0);
      pop_data        = entries_ff[rd_ptr_ff];
      wr_en           = push && !status.full;
      rd_en           = pop && status.nonempty;
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `VCFB_ASSERT_NEVER(queue_count_bound, clock, reset, count_ff > CNT_W'(DEPTH))

endmodule

`default_nettype wire

>>> sv/vcfb_back.sv
`default_nettype none

`include "voxel_cube_frame_buffer_core_defines.svh"

module vcfb_back import vcfb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [3:0]       edge_size,
   input  wire queue_status_type q_status,
   input  wire cmd_type          q_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_voxel_value,
   output logic                  rsp_coord_in_range
);

   // Low edge^2 bits of a layer
   function automatic logic [LAYER_BITS-1:0] vis_mask(input logic [3:0] edge_n);
      logic [LAYER_BITS-1:0] m;
      int sq;
      sq = int'(edge_n) * int'(edge_n);
      for (int p = 0; p < LAYER_BITS; p++) begin
         m[p] = (p < sq);
      end
      return m;
   endfunction

   // Whole packed bytes covering the edge^2 voxels
   function automatic logic [LAYER_BITS-1:0] fill_mask(input logic [3:0] edge_n);
      logic [LAYER_BITS-1:0] m;
      int sq;
      sq = int'(edge_n) * int'(edge_n);
      for (int b = 0; b < LAYER_BITS / 8; b++) begin
         m[b*8 +: 8] = {8{(b * 8 < sq)}};
      end
      return m;
   endfunction

   // Outer ring of the edge x edge square
   function automatic logic [LAYER_BITS-1:0] border_mask(input logic [3:0] edge_n);
      logic [LAYER_BITS-1:0] m;
      logic [6:0] pos;
      m = '0;
      for (int y = 0; y < MAX_EDGE; y++) begin
         for (int x = 0; x < MAX_EDGE; x++) begin
            pos = 7'(y * int'(edge_n) + x);
            if (x < int'(edge_n) && y < int'(edge_n) &&
                (x == 0 || y == 0 || x == int'(edge_n) - 1 || y == int'(edge_n) - 1)) begin
               m[pos[5:0]] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   // Bit-reversed pattern repeated over every byte
   function automatic logic [LAYER_BITS-1:0] pattern_word(input logic [7:0] pat);
      logic [7:0] rev;
      for (int i = 0; i < 8; i++) begin
         rev[i] = pat[7-i];
      end
      return {(LAYER_BITS / 8){rev}};
   endfunction

   back_state_type        state_ff, state_in;
   logic [LAYER_BITS-1:0] store_ff [LAYER_COUNT];
   logic [LAYER_BITS-1:0] store_in [LAYER_COUNT];
   logic [2:0]            cnt_ff, cnt_in;
   logic [3:0]            clr_ff, clr_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_value_ff, rsp_value_in;
   logic                  rsp_range_ff, rsp_range_in;

   logic                  slot_free;
   logic                  rot_step;
   logic                  finish;
   logic [LAYER_BITS-1:0] cur;
   logic [LAYER_BITS-1:0] bit_sel;
   logic [LAYER_BITS-1:0] vis, fm, bm, pw;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (q_status.nonempty && slot_free && q_data.opcode == OP_SHIFT) begin
               state_in = BACK_ROTATE;
            end
         end
         BACK_ROTATE: begin
            if (cnt_ff == 3'd0 && slot_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      slot_free = !rsp_vld_ff || !rsp_stall;
      pop       = (state_ff == BACK_IDLE) && q_status.nonempty && slot_free;
      rot_step  = (state_ff == BACK_ROTATE) && (cnt_ff != 3'd0);
      finish    = (state_ff == BACK_ROTATE) && (cnt_ff == 3'd0) && slot_free;
   end

   // Execute on the layer store
   always_comb begin
      vis     = vis_mask(edge_size);
      fm      = fill_mask(edge_size);
      bm      = border_mask(edge_size);
      pw      = pattern_word(q_data.pattern_byte);
      cur     = store_ff[q_data.z_coord];
      bit_sel = {{(LAYER_BITS-1){1'b0}}, 1'b1} << q_data.bit_pos;
      for (int l = 0; l < LAYER_COUNT; l++) begin
         store_in[l] = store_ff[l];
      end
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      rsp_vld_in   = rsp_vld_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_range_in = rsp_range_ff;

      if (pop) begin
         if (q_data.opcode != OP_SHIFT) begin
            rsp_vld_in   = 1'b1;
            rsp_value_in = 1'b0;
            rsp_range_in = q_data.in_range;
         end
         unique case (q_data.opcode)
            OP_READ: begin
               rsp_value_in = cur[q_data.bit_pos] & q_data.in_range;
            end
            OP_SET: begin
               if (q_data.in_range) store_in[q_data.z_coord] = cur | bit_sel;
            end
            OP_CLEAR: begin
               if (q_data.in_range) store_in[q_data.z_coord] = cur & ~bit_sel;
            end
            OP_FLIP: begin
               if (q_data.in_range) store_in[q_data.z_coord] = cur ^ bit_sel;
            end
            OP_FILL_CUBE: begin
               for (int l = 0; l < LAYER_COUNT; l++) begin
                  if (l < int'(edge_size)) begin
                     store_in[l] = (store_ff[l] & ~fm) | (pw & fm);
                  end
               end
            end
            OP_LAYER_FULL: begin
               if (q_data.in_range) store_in[q_data.z_coord] = cur | vis;
            end
            OP_LAYER_EMPTY: begin
               if (q_data.in_range) store_in[q_data.z_coord] = cur & ~vis;
            end
            OP_LAYER_BORDER: begin
               if (q_data.in_range) store_in[q_data.z_coord] = cur | bm;
            end
            OP_LAYER_PATTERN: begin
               if (q_data.in_range) store_in[q_data.z_coord] = (cur & ~fm) | (pw & fm);
            end
            OP_SHIFT: begin
               cnt_in = q_data.rot_count;
               clr_in = q_data.clear_count;
            end
            default: begin
            end
         endcase
      end

      // Rotate the used layers down by one
      if (rot_step) begin
         for (int l = 0; l < LAYER_COUNT; l++) begin
            if (l < int'(edge_size)) begin
               store_in[l] = (l == int'(edge_size) - 1) ? store_ff[0]
                                                       : store_ff[(l + 1) % LAYER_COUNT];
            end
         end
         cnt_in = cnt_ff - 3'd1;
      end

      // Drop the vacated top layers and report the shift
      if (finish) begin
         for (int l = 0; l < LAYER_COUNT; l++) begin
            if (l < int'(edge_size) && (l + int'(clr_ff)) >= int'(edge_size)) begin
               store_in[l] = store_ff[l] & ~vis;
            end
         end
         rsp_vld_in   = 1'b1;
         rsp_value_in = 1'b0;
         rsp_range_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         rsp_vld_ff <= 1'b0;
         for (int l = 0; l < LAYER_COUNT; l++) begin
            store_ff[l] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         for (int l = 0; l < LAYER_COUNT; l++) begin
            store_ff[l] <= store_in[l];
         end
      end
      cnt_ff       <= cnt_in;
      clr_ff       <= clr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_range_ff <= rsp_range_in;
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_voxel_value    = rsp_value_ff;
   assign rsp_coord_in_range = rsp_range_ff;

   `VCFB_ASSERT_NEXT(back_rotate_countdown, clock, reset, state_ff == BACK_ROTATE && cnt_ff != 3'd0, state_ff == BACK_ROTATE && cnt_ff == $past(cnt_ff) - 3'd1)
   `VCFB_ASSERT_NEVER(back_rsp_overwrite, clock, reset, (pop || finish) && rsp_vld_ff && rsp_stall)

endmodule

`default_nettype wire
